@@ rtl/core/ifhu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 forward header update - shared package
// Payload structs, status and queue operation codes, and the ones' complement
// add used by the checksum datapath.
// ----------------------------------------------------------------------------
package ifhu_pkg;

  // Byte positions inside the header.
  localparam logic [5:0] TTL_POS     = 6'd8;
  localparam logic [5:0] CSUM_HI_POS = 6'd10;
  localparam logic [5:0] CSUM_LO_POS = 6'd11;
  localparam logic [5:0] FIRST_WORD_POS = 6'd1;
  localparam logic [3:0] MIN_IHL     = 4'd5;

  // Default depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_CKSUM = 2'd1,
    STATUS_SHORT     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_WORD  = 2'd0,   // add a word to the running sum
    OP_LAST  = 2'd1,   // add the last word and finish the header
    OP_SHORT = 2'd2    // header length field below five words
  } op_kind_t;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       start_req;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  new_ttl;
    logic [15:0] new_checksum;
  } out_item_t;

  typedef struct packed {
    op_kind_t    kind;
    logic        first;      // sum restarts from zero with this word
    logic [15:0] word;
    logic [7:0]  ttl;
    logic [15:0] rx_cksum;
  } q_entry_t;

  // Ones' complement 16-bit add with the end-around carry folded once.
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'b0, s[16]};
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/ifhu_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 forward header update - front end
// Accepts header bytes, tracks the byte position, pairs bytes into words and
// pushes one queue entry per completed word or short-header start.
// ----------------------------------------------------------------------------
module ifhu_front
  import ifhu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  input  wire logic     q_full,
  output logic          q_push,
  output q_entry_t      q_entry
);

  logic [5:0]  byte_index;
  logic [5:0]  header_length;
  logic        active;
  logic [7:0]  high_byte;
  logic [15:0] rx_cksum;
  logic [7:0]  ttl_seen;

  logic        accept;
  logic [3:0]  ihl;
  logic        odd_byte;
  logic [6:0]  idx_plus;
  logic        is_last;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign ihl      = in_data.header_byte[3:0];
  assign odd_byte = byte_index[0];
  assign idx_plus = {1'b0, byte_index} + 7'd1;
  assign is_last  = idx_plus >= {1'b0, header_length};

  always_comb begin
    q_push           = 1'b0;
    q_entry.kind     = OP_WORD;
    q_entry.first    = (byte_index == FIRST_WORD_POS);
    q_entry.word     = {high_byte, in_data.header_byte};
    q_entry.ttl      = ttl_seen;
    q_entry.rx_cksum = rx_cksum;
    if (in_data.start_req) begin
      q_entry.kind = OP_SHORT;
      q_push       = accept && (ihl < MIN_IHL);
    end else begin
      if (byte_index == CSUM_LO_POS) begin
        // The checksum field counts as zero in the sum.
        q_entry.word     = 16'h0000;
        q_entry.rx_cksum = {rx_cksum[15:8], in_data.header_byte};
      end
      q_entry.kind = is_last ? OP_LAST : OP_WORD;
      q_push       = accept && active && odd_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= '0;
      header_length <= '0;
      active        <= 1'b0;
      high_byte     <= '0;
      rx_cksum      <= '0;
      ttl_seen      <= '0;
    end else if (accept) begin
      if (in_data.start_req) begin
        header_length <= {ihl, 2'b00};
        rx_cksum      <= '0;
        ttl_seen      <= '0;
        if (ihl < MIN_IHL) begin
          active     <= 1'b0;
          byte_index <= '0;
          high_byte  <= '0;
        end else begin
          active     <= 1'b1;
          byte_index <= FIRST_WORD_POS;
          high_byte  <= in_data.header_byte;
        end
      end else if (active) begin
        if (!odd_byte) begin
          if (byte_index == TTL_POS) begin
            ttl_seen  <= in_data.header_byte;
            high_byte <= '0;
          end else if (byte_index == CSUM_HI_POS) begin
            rx_cksum  <= {in_data.header_byte, 8'h00};
            high_byte <= '0;
          end else begin
            high_byte <= in_data.header_byte;
          end
        end else if (byte_index == CSUM_LO_POS) begin
          rx_cksum <= {rx_cksum[15:8], in_data.header_byte};
        end
        if (is_last) begin
          active <= 1'b0;
        end else begin
          byte_index <= idx_plus[5:0];
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/ifhu_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 forward header update - work queue
// Small first-in first-out queue of word operations between front and back.
// ----------------------------------------------------------------------------
module ifhu_fifo
  import ifhu_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH
)
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire q_entry_t push_data,
  input  wire logic     pop,
  output q_entry_t      head,
  output logic          empty,
  output logic          full
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  q_entry_t        mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign empty   = (count == '0);
  assign full    = (count == FullCnt);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/ifhu_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 forward header update - back end
// Accumulates words in ones' complement, then in a finish stage checks the
// received checksum and forms the new TTL and checksum into the output register.
// ----------------------------------------------------------------------------
module ifhu_back
  import ifhu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire q_entry_t q_head,
  input  wire logic     q_empty,
  output logic          q_pop,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  logic [15:0] word_sum;
  logic [15:0] acc_sum;

  // Finish stage.
  logic        fin_valid;
  op_kind_t    fin_kind;
  logic [15:0] fin_sum;
  logic [7:0]  fin_ttl;
  logic [15:0] fin_rx;

  logic        out_free;
  logic        fin_ready;
  logic        head_is_word;
  logic [15:0] s_old;
  logic [15:0] s_new;
  logic [7:0]  ttl_new;
  out_item_t   result;

  assign out_free     = !out_valid || out_ready;
  assign fin_ready    = !fin_valid || out_free;
  assign head_is_word = (q_head.kind == OP_WORD);
  assign q_pop        = !q_empty && (head_is_word || fin_ready);
  assign acc_sum      = oc_add(q_head.first ? 16'h0000 : word_sum, q_head.word);

  always_comb begin
    ttl_new = fin_ttl - 8'd1;
    s_old   = oc_add(fin_sum, {fin_ttl, 8'h00});
    s_new   = oc_add(fin_sum, {ttl_new, 8'h00});
    result  = '{status: STATUS_OK, new_ttl: ttl_new, new_checksum: ~s_new};
    if (fin_kind == OP_SHORT) begin
      result = '{status: STATUS_SHORT, new_ttl: 8'h00, new_checksum: 16'h0000};
    end else if (~s_old != fin_rx) begin
      result = '{status: STATUS_BAD_CKSUM, new_ttl: 8'h00, new_checksum: 16'h0000};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_sum  <= '0;
      fin_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop && head_is_word) begin
        word_sum <= acc_sum;
      end
      if (fin_ready) begin
        fin_valid <= q_pop && !head_is_word;
      end
      if (out_free) begin
        out_valid <= fin_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_ready && q_pop && !head_is_word) begin
      fin_kind <= q_head.kind;
      fin_sum  <= acc_sum;
      fin_ttl  <= q_head.ttl;
      fin_rx   <= q_head.rx_cksum;
    end
    if (out_free && fin_valid) begin
      out_data <= result;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/ipv4_forward_header_update.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 forward header update
// Checks an IPv4 header checksum byte by byte, then reports the decremented
// TTL and the checksum recomputed with it.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Item
//  in        input      in_valid / in_ready    in_item_t: header_byte, start_req
//  out       output     out_valid / out_ready  out_item_t: status, new_ttl,
//                                              new_checksum
//
// One header byte is accepted per cycle while the queue has room. A byte with
// start_req begins a new header (and drops one in progress); the low nibble
// gives the length in 32-bit words. The front end pairs bytes into 16-bit
// words and queues them; the back end adds one queued word per cycle while
// words are queued, twice what a byte-wide input can supply, so sustained
// rate is one byte per cycle, set by the input width. The result for a
// header passes through the queue, the finish stage and the output register
// after its last byte is accepted. A short header length gives its error
// result from the start byte alone, through the same path.
// Reset is synchronous and clears all control state. When out_ready is held
// low, the output register, the finish stage and then the queue fill, and
// only then does in_ready drop; words queued ahead of a waiting last word are
// still summed meanwhile.
//
module ipv4_forward_header_update
  import ifhu_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
)
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  // Queue between the classifier and the checksum engine.
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;
  q_entry_t q_entry;
  q_entry_t q_head;

  ifhu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  ifhu_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_entry),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  ifhu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The front end must never push into a full queue, or a word is lost.
  a_no_push_when_full : assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("word pushed into a full queue");

  // Error results carry zero TTL and checksum fields.
  a_error_fields_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != STATUS_OK) |->
      (out_data.new_ttl == 8'h00 && out_data.new_checksum == 16'h0000))
    else $error("error result with nonzero fields");

  // A word popped from an empty queue would be invented.
  a_no_pop_when_empty : assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_empty))
    else $error("pop from an empty queue");

endmodule
`default_nettype wire

@@ tb/header_update_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IPv4 forward header update - result checker
// Watches both channels of the block, tracks each header byte by byte and
// compares every result item against the oldest predicted one.
// ----------------------------------------------------------------------------
module header_update_checker
  import ifhu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        mismatches,
  output int        awaiting
);

  // Predictor copy of the header walk.
  logic [5:0]  pos_q;
  logic [5:0]  len_q;
  logic        busy_q;
  logic [15:0] sum_q;
  logic [7:0]  hi_q;
  logic [15:0] rx_csum_q;
  logic [7:0]  ttl_q;

  out_item_t expected_updates[$];
  out_item_t want;
  int        errs;

  function automatic logic [15:0] add_ones(input logic [15:0] x, input logic [15:0] y);
    logic [16:0] t;
    t = {1'b0, x} + {1'b0, y};
    if (t[16])
      return t[15:0] + 16'd1;
    else
      return t[15:0];
  endfunction

  task automatic track_header_byte(input in_item_t it);
    logic [15:0] wd;
    logic [15:0] old_sum;
    logic [15:0] new_sum;
    logic [7:0]  ttl_dec;
    out_item_t   r;
    if (it.start_req) begin
      pos_q     = '0;
      sum_q     = '0;
      hi_q      = '0;
      rx_csum_q = '0;
      ttl_q     = '0;
      len_q     = {it.header_byte[3:0], 2'b00};
      if (it.header_byte[3:0] < MIN_IHL) begin
        busy_q = 1'b0;
        r.status       = STATUS_SHORT;
        r.new_ttl      = '0;
        r.new_checksum = '0;
        expected_updates.push_back(r);
      end else begin
        busy_q = 1'b1;
        hi_q   = it.header_byte;
        pos_q  = FIRST_WORD_POS;
      end
    end else if (busy_q) begin
      if (!pos_q[0]) begin
        // The TTL and the checksum high byte are held aside; the TTL's word
        // partner is added with a zero high byte and the checksum word as zero.
        if (pos_q == TTL_POS) begin
          ttl_q = it.header_byte;
          hi_q  = '0;
        end else if (pos_q == CSUM_HI_POS) begin
          rx_csum_q = {it.header_byte, 8'h00};
          hi_q      = '0;
        end else begin
          hi_q = it.header_byte;
        end
      end else begin
        if (pos_q == CSUM_LO_POS) begin
          rx_csum_q = rx_csum_q | {8'h00, it.header_byte};
          wd        = '0;
        end else begin
          wd = {hi_q, it.header_byte};
        end
        sum_q = add_ones(sum_q, wd);
      end
      if (int'(pos_q) + 1 >= int'(len_q)) begin
        busy_q  = 1'b0;
        old_sum = add_ones(sum_q, {ttl_q, 8'h00});
        ttl_dec = ttl_q - 8'd1;
        if ((~old_sum) != rx_csum_q) begin
          r.status       = STATUS_BAD_CKSUM;
          r.new_ttl      = '0;
          r.new_checksum = '0;
        end else begin
          new_sum        = add_ones(sum_q, {ttl_dec, 8'h00});
          r.status       = STATUS_OK;
          r.new_ttl      = ttl_dec;
          r.new_checksum = ~new_sum;
        end
        expected_updates.push_back(r);
      end else begin
        pos_q = pos_q + 6'd1;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pos_q      = '0;
      len_q      = '0;
      busy_q     = 1'b0;
      sum_q      = '0;
      hi_q       = '0;
      rx_csum_q  = '0;
      ttl_q      = '0;
      errs       = 0;
      expected_updates.delete();
      mismatches <= 0;
      awaiting   <= 0;
    end else begin
      if (in_valid && in_ready)
        track_header_byte(in_data);
      if (out_valid && out_ready) begin
        if (expected_updates.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, out_data);
          errs++;
        end else begin
          want = expected_updates.pop_front();
          if (out_data.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status,
                     out_data.status);
            errs++;
          end
          if (out_data.new_ttl !== want.new_ttl) begin
            $display("%0t: new_ttl expected %0d, got %0d", $time, want.new_ttl,
                     out_data.new_ttl);
            errs++;
          end
          if (out_data.new_checksum !== want.new_checksum) begin
            $display("%0t: new_checksum expected %h, got %h", $time,
                     want.new_checksum, out_data.new_checksum);
            errs++;
          end
        end
      end
      mismatches <= errs;
      awaiting   <= expected_updates.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IPv4 forward header update - testbench
// Streams IPv4 headers into the block one byte per item with random idle
// gaps on the input and random back-pressure on the output, while a separate
// checker predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module testbench;
  import ifhu_pkg::*;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  int        mismatches;
  int        awaiting;

  // Idle rates in percent for the two sides, and the count of header bytes
  // that the block actually acts on.
  int tx_idle_pct;
  int rx_idle_pct;
  int sent;

  ipv4_forward_header_update dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  header_update_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The receiver drops ready at random, at the rate the current phase sets.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Presents one byte. Before it the sender may sit idle, with junk on the
  // data lines. Once valid is raised it stays up with the same byte until
  // the block takes it; the acceptance edge is the one at which ready was
  // already high beforehand.
  task automatic send_byte(input logic [7:0] b, input logic s, input bit counted);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      in_data  <= in_item_t'($urandom_range(511));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{header_byte: b, start_req: s};
    do @(posedge clk); while (in_ready !== 1'b1);
    if (counted)
      sent++;
  endtask

  // Builds a header of ihl words with a correct checksum, optionally flips
  // one bit in it, and sends its first stop_after bytes. A stop_after
  // shorter than the header leaves it unfinished, so that whatever comes
  // next either restarts the block or runs on into the broken header.
  task automatic send_header(input logic [3:0] ihl, input logic [7:0] ttl,
                             input bit corrupt, input int stop_after);
    logic [7:0]  hdr [0:63];
    logic [16:0] acc;
    logic [15:0] fold;
    int          nbytes;
    int          k;
    nbytes = int'(ihl) * 4;
    for (k = 0; k < nbytes; k++)
      hdr[k] = 8'($urandom_range(255));
    hdr[0][3:0] = ihl;
    hdr[8]      = ttl;
    hdr[10]     = 8'h00;
    hdr[11]     = 8'h00;
    fold = '0;
    for (k = 0; k < nbytes; k += 2) begin
      acc  = {1'b0, fold} + {1'b0, hdr[k], hdr[k + 1]};
      fold = acc[15:0] + {15'b0, acc[16]};
    end
    {hdr[10], hdr[11]} = ~fold;
    if (corrupt) begin
      k = $urandom_range(nbytes - 1, 1);
      hdr[k] = hdr[k] ^ (8'h01 << $urandom_range(7));
    end
    for (k = 0; k < nbytes && k < stop_after; k++)
      send_byte(hdr[k], k == 0, 1'b1);
  endtask

  // Holds the sender off until every predicted result has come out. The
  // first edge only lets the checker's count catch up with the last byte.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0)
      @(posedge clk);
  endtask

  // One phase of random traffic. Most of it is whole headers with random
  // content, some with one bit flipped, since those reach the checksum and
  // TTL logic. The rest are cut-off headers, short header lengths and stray
  // bytes that the block should skip while idle.
  task automatic run_phase(input int tx_pct, input int rx_pct, input int budget);
    int          goal;
    int          pick;
    logic [3:0]  ihl;
    logic [7:0]  ttl;
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    goal = sent + budget;
    while (sent < goal) begin
      pick = $urandom_range(99);
      if ($urandom_range(9) < 8)
        ihl = 4'($urandom_range(6, 5));
      else
        ihl = 4'($urandom_range(15, 7));
      case ($urandom_range(7))
        0:       ttl = 8'h00;
        1:       ttl = 8'h01;
        2:       ttl = 8'hff;
        default: ttl = 8'($urandom_range(255));
      endcase
      if (pick < 70)
        send_header(ihl, ttl, $urandom_range(99) < 15, 64);
      else if (pick < 80)
        send_header(ihl, ttl, 1'b0, $urandom_range(int'(ihl) * 4 - 1, 1));
      else if (pick < 88)
        send_byte({4'($urandom_range(15)), 4'($urandom_range(4))}, 1'b1, 1'b1);
      else
        repeat ($urandom_range(4, 1))
          send_byte(8'($urandom_range(255)), 1'b0, 1'b0);
    end
  endtask

  initial begin
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    in_data     <= '0;
    rx_idle_pct <= 0;
    tx_idle_pct = 0;
    sent        = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, under the first phase's idle rates.
    tx_idle_pct = 31;
    rx_idle_pct <= 82;
    // Every short header length, with the upper nibble at both extremes.
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'hf1, 1'b1, 1'b1);
    send_byte(8'h42, 1'b1, 1'b1);
    send_byte(8'hf3, 1'b1, 1'b1);
    send_byte(8'h44, 1'b1, 1'b1);
    // A stray byte while idle must be ignored.
    send_byte(8'hff, 1'b0, 1'b0);
    // Minimum header with TTL zero, so the decrement wraps to 255.
    send_header(4'd5, 8'h00, 1'b0, 64);
    // A header dropped after three bytes by a new start.
    send_header(4'd5, 8'h40, 1'b0, 3);
    // Maximum header length with TTL 255, then one with a broken checksum.
    send_header(4'd15, 8'hff, 1'b0, 64);
    send_header(4'd5, 8'h01, 1'b1, 64);
    wait_for_drain();

    // Random part: slow receiver, then slow sender, then full speed. The
    // sender stops between phases until every result is out.
    run_phase(31, 82, 650);
    wait_for_drain();
    run_phase(82, 31, 650);
    wait_for_drain();
    run_phase(0, 0, 650);
    wait_for_drain();

    // Wait on past the last result, so that a stray late item is seen.
    repeat (20) @(posedge clk);
    if (mismatches == 0 && awaiting == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/ifhu_pkg.sv
rtl/core/ifhu_front.sv
rtl/core/ifhu_fifo.sv
rtl/core/ifhu_back.sv
rtl/core/ipv4_forward_header_update.sv
tb/header_update_checker.sv
tb/testbench.sv
